// ===== hw/rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// opcodes shared by the shape intersection tester and its checker
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int OP_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_CIRC_CIRC = 3'd0;
  localparam logic [OP_BITS-1:0] OP_CIRC_RECT = 3'd1;
  localparam logic [OP_BITS-1:0] OP_RECT_RECT = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PT_CIRC   = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PT_RECT   = 3'd4;

endpackage

// ===== hw/rtl/shape_intersection_tester_unit.sv =====
// ----------------------------------------------------------------------------
// shape_intersection_tester_unit
// pipelined hit test between two shapes chosen by an opcode
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  input     in_op, in_a_*, in_b_*                   start && !busy
//  result    out_hit                                 out_valid, one cycle
//
//  one item per clock, result registered at the end of the last stage below
//  stages: operand arithmetic, magnitude and select, squaring, sum compare
//  rst_n clears the valid bits of every stage; busy stays low
//  the receiver cannot stall, so the pipeline never holds
module shape_intersection_tester_unit
  import sit_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_BITS-1:0]           in_op,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic [COORD_BITS-2:0]        in_a_w,
  input  logic [COORD_BITS-2:0]        in_a_h,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic [COORD_BITS-2:0]        in_b_w,
  input  logic [COORD_BITS-2:0]        in_b_h,
  output logic                         out_valid,
  output logic                         out_hit
);

  localparam int N = COORD_BITS;
  localparam int D = COORD_BITS + 3;
  localparam int M = COORD_BITS + 2;
  localparam int P = 2 * M;

  function automatic logic [D-1:0] mag_f(input logic signed [D-1:0] v);
    mag_f = v[D-1] ? D'(-v) : D'(v);
  endfunction

  // stage 1: operand arithmetic
  logic signed [D-1:0] ax_e, ay_e, bx_e, by_e;
  logic signed [D-1:0] ax2_e, ay2_e, bx2_e, by2_e;
  logic signed [D-1:0] aw_e, ah_e, bw_e, bh_e;

  assign ax_e  = {{3{in_a_x[N-1]}}, in_a_x};
  assign ay_e  = {{3{in_a_y[N-1]}}, in_a_y};
  assign bx_e  = {{3{in_b_x[N-1]}}, in_b_x};
  assign by_e  = {{3{in_b_y[N-1]}}, in_b_y};
  assign ax2_e = {{2{in_a_x[N-1]}}, in_a_x, 1'b0};
  assign ay2_e = {{2{in_a_y[N-1]}}, in_a_y, 1'b0};
  assign bx2_e = {{2{in_b_x[N-1]}}, in_b_x, 1'b0};
  assign by2_e = {{2{in_b_y[N-1]}}, in_b_y, 1'b0};
  assign aw_e  = {4'b0, in_a_w};
  assign ah_e  = {4'b0, in_a_h};
  assign bw_e  = {4'b0, in_b_w};
  assign bh_e  = {4'b0, in_b_h};

  logic                v_s1_r;
  logic [OP_BITS-1:0]  op_s1_r;
  logic signed [D-1:0] dx0_s1_r, dy0_s1_r, cx1_s1_r, cy1_s1_r;
  logic signed [D-1:0] cx2_s1_r, cy2_s1_r, ex_s1_r, ey_s1_r;
  logic [M-1:0]        bw_s1_r, bh_s1_r, sw_s1_r, sh_s1_r, aw2_s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
    end else begin
      v_s1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_s1_r  <= in_op;
    dx0_s1_r <= ax_e - bx_e;
    dy0_s1_r <= ay_e - by_e;
    cx1_s1_r <= ax2_e - (bx2_e + bw_e);
    cy1_s1_r <= ay2_e - (by2_e + bh_e);
    cx2_s1_r <= (ax2_e + aw_e) - (bx2_e + bw_e);
    cy2_s1_r <= (ay2_e + ah_e) - (by2_e + bh_e);
    ex_s1_r  <= (bx_e + bw_e) - ax_e;
    ey_s1_r  <= (by_e + bh_e) - ay_e;
    bw_s1_r  <= M'(in_b_w);
    bh_s1_r  <= M'(in_b_h);
    sw_s1_r  <= M'(in_a_w) + M'(in_b_w);
    sh_s1_r  <= M'(in_a_h) + M'(in_b_h);
    aw2_s1_r <= {2'b0, in_a_w, 1'b0};
  end

  // stage 2: magnitudes and per-opcode selection
  logic [D-1:0]        mdx0, mdy0, mcx1, mcy1, mcx2, mcy2;
  logic signed [D-1:0] side, top;
  logic                side_pos, top_pos;
  logic [M-1:0]        p_nxt, q_nxt, r_nxt;
  logic                sq_nxt, dir_nxt;

  assign mdx0     = mag_f(dx0_s1_r);
  assign mdy0     = mag_f(dy0_s1_r);
  assign mcx1     = mag_f(cx1_s1_r);
  assign mcy1     = mag_f(cy1_s1_r);
  assign mcx2     = mag_f(cx2_s1_r);
  assign mcy2     = mag_f(cy2_s1_r);
  assign side     = $signed(mcx1) - $signed({1'b0, bw_s1_r});
  assign top      = $signed(mcy1) - $signed({1'b0, bh_s1_r});
  assign side_pos = !side[D-1] && (side != '0);
  assign top_pos  = !top[D-1] && (top != '0);

  always_comb begin
    p_nxt   = mdx0[M-1:0];
    q_nxt   = mdy0[M-1:0];
    r_nxt   = sw_s1_r;
    sq_nxt  = 1'b0;
    dir_nxt = 1'b0;
    unique case (op_s1_r)
      OP_CIRC_CIRC: begin
        sq_nxt = 1'b1;
      end
      OP_CIRC_RECT: begin
        p_nxt = side[M-1:0];
        q_nxt = top[M-1:0];
        r_nxt = aw2_s1_r;
        if (side_pos && top_pos) begin
          sq_nxt = 1'b1;
        end else if (side_pos) begin
          dir_nxt = side[M-1:0] <= aw2_s1_r;
        end else if (top_pos) begin
          dir_nxt = top[M-1:0] <= aw2_s1_r;
        end else begin
          dir_nxt = 1'b1;
        end
      end
      OP_RECT_RECT: begin
        dir_nxt = (mcx2 <= {1'b0, sw_s1_r}) && (mcy2 <= {1'b0, sh_s1_r});
      end
      OP_PT_CIRC: begin
        r_nxt  = bw_s1_r;
        sq_nxt = 1'b1;
      end
      OP_PT_RECT: begin
        dir_nxt = !dx0_s1_r[D-1] && !ex_s1_r[D-1] && !dy0_s1_r[D-1] && !ey_s1_r[D-1];
      end
      default: begin
        dir_nxt = 1'b0;
      end
    endcase
  end

  logic         v_s2_r, sq_s2_r, dir_s2_r;
  logic [M-1:0] p_s2_r, q_s2_r, r_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s2_r <= 1'b0;
    end else begin
      v_s2_r <= v_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_s2_r  <= sq_nxt;
    dir_s2_r <= dir_nxt;
    p_s2_r   <= p_nxt;
    q_s2_r   <= q_nxt;
    r_s2_r   <= r_nxt;
  end

  // stage 3: squares
  logic         v_s3_r, sq_s3_r, dir_s3_r;
  logic [P-1:0] pp_s3_r, qq_s3_r, rr_s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s3_r <= 1'b0;
    end else begin
      v_s3_r <= v_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_s3_r  <= sq_s2_r;
    dir_s3_r <= dir_s2_r;
    pp_s3_r  <= P'(p_s2_r) * P'(p_s2_r);
    qq_s3_r  <= P'(q_s2_r) * P'(q_s2_r);
    rr_s3_r  <= P'(r_s2_r) * P'(r_s2_r);
  end

  // stage 4: sum of squares against squared reach
  logic [P:0] sum_sq;
  logic       hit_nxt;

  assign sum_sq  = (P+1)'(pp_s3_r) + (P+1)'(qq_s3_r);
  assign hit_nxt = sq_s3_r ? (sum_sq <= {1'b0, rr_s3_r}) : dir_s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_s3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_hit <= hit_nxt;
  end

  assign busy = 1'b0;

endmodule

// ===== hw/rtl/sit_checker.sv =====
// ----------------------------------------------------------------------------
// sit_checker
// port-level checks on the shape intersection tester
// ----------------------------------------------------------------------------
module sit_checker
  import sit_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [OP_BITS-1:0]           in_op,
  input logic signed [COORD_BITS-1:0] in_a_x,
  input logic signed [COORD_BITS-1:0] in_a_y,
  input logic signed [COORD_BITS-1:0] in_b_x,
  input logic signed [COORD_BITS-1:0] in_b_y,
  input logic                         out_valid,
  input logic                         out_hit
);

  logic xfer;
  logic bad_op;

  assign xfer   = start && !busy;
  assign bad_op = (in_op != OP_CIRC_CIRC) && (in_op != OP_CIRC_RECT) &&
                  (in_op != OP_RECT_RECT) && (in_op != OP_PT_CIRC) &&
                  (in_op != OP_PT_RECT);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |-> ##4 out_valid)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !xfer |-> ##4 !out_valid)
    else $error("result without transfer");

  a_bad_op_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && bad_op) |-> ##4 (out_valid && !out_hit))
    else $error("unused opcode gave a hit");

  a_corner_point: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && (in_op == OP_PT_RECT) && (in_a_x == in_b_x) && (in_a_y == in_b_y))
      |-> ##4 out_hit)
    else $error("point on rectangle corner missed");

endmodule

bind shape_intersection_tester_unit sit_checker #(.COORD_BITS(COORD_BITS)) u_sit_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_op    (in_op),
  .in_a_x   (in_a_x),
  .in_a_y   (in_a_y),
  .in_b_x   (in_b_x),
  .in_b_y   (in_b_y),
  .out_valid(out_valid),
  .out_hit  (out_hit)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for shape_intersection_tester_unit: directed corner,
// edge and border cases, then mostly near-boundary random shape pairs, each
// hit predicted by an exact integer model, doubled for rects, checked in order
// ----------------------------------------------------------------------------
module testbench;
  import sit_pkg::*;

  localparam int COORD_BITS    = 16;
  localparam int CLK_PERIOD    = 4;
  localparam int RANDOM_ITEMS  = 700;
  localparam int IDLE_LIMIT    = 200;
  localparam int DRAIN_CYCLES  = 12;

  typedef struct packed {
    logic [OP_BITS-1:0]           op;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic [COORD_BITS-2:0]        a_w;
    logic [COORD_BITS-2:0]        a_h;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [COORD_BITS-2:0]        b_w;
    logic [COORD_BITS-2:0]        b_h;
  } shape_pair_t;

  class hit_scoreboard;
    bit expected_hits[$];
    int error_count;

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function bit squares_within(longint p, longint q, longint r);
      return p * p + q * q <= r * r;
    endfunction

    function bit predict_hit(shape_pair_t s);
      longint ax, ay, aw, ah, bx, by, bw, bh, dx, dy, side, top;
      ax = longint'($signed(s.a_x));
      ay = longint'($signed(s.a_y));
      bx = longint'($signed(s.b_x));
      by = longint'($signed(s.b_y));
      aw = longint'(s.a_w);
      ah = longint'(s.a_h);
      bw = longint'(s.b_w);
      bh = longint'(s.b_h);
      case (s.op)
        OP_CIRC_CIRC: return squares_within(ax - bx, ay - by, aw + bw);
        OP_CIRC_RECT: begin
          // doubled scale: rect centre is 2x+w, half extent is w
          dx   = magnitude(2 * ax - (2 * bx + bw));
          dy   = magnitude(2 * ay - (2 * by + bh));
          side = dx - bw;
          top  = dy - bh;
          if (side > 0 && top > 0) return squares_within(side, top, 2 * aw);
          else if (side > 0) return side <= 2 * aw;
          else if (top > 0) return top <= 2 * aw;
          else return 1'b1;
        end
        OP_RECT_RECT: begin
          dx = magnitude((2 * ax + aw) - (2 * bx + bw));
          dy = magnitude((2 * ay + ah) - (2 * by + bh));
          return (dx <= aw + bw) && (dy <= ah + bh);
        end
        OP_PT_CIRC: return squares_within(ax - bx, ay - by, bw);
        OP_PT_RECT: return (bx <= ax) && (ax <= bx + bw) && (by <= ay) && (ay <= by + bh);
        default: return 1'b0;
      endcase
    endfunction

    function void note_transfer(shape_pair_t s);
      expected_hits.push_back(predict_hit(s));
    endfunction

    function void check_result(logic hit);
      bit want;
      if (expected_hits.size() == 0) begin
        $display("%0t: result with none expected: expected none, actual hit %b", $time, hit);
        error_count++;
        return;
      end
      want = expected_hits.pop_front();
      if (hit !== want) begin
        $display("%0t: hit mismatch: expected %b, actual %b", $time, want, hit);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  shape_pair_t drive_pair = '0;
  logic        busy;
  logic        out_valid;
  logic        out_hit;
  int          idle_cycles = 0;

  hit_scoreboard hits = new;

  shape_intersection_tester_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_op    (drive_pair.op),
    .in_a_x   (drive_pair.a_x),
    .in_a_y   (drive_pair.a_y),
    .in_a_w   (drive_pair.a_w),
    .in_a_h   (drive_pair.a_h),
    .in_b_x   (drive_pair.b_x),
    .in_b_y   (drive_pair.b_y),
    .in_b_w   (drive_pair.b_w),
    .in_b_h   (drive_pair.b_h),
    .out_valid(out_valid),
    .out_hit  (out_hit)
  );

  always #(CLK_PERIOD / 2.0) clk = ~clk;

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) hits.note_transfer(drive_pair);
      if (out_valid) hits.check_result(out_hit);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic shape_pair_t pair_of(logic [OP_BITS-1:0] op, int ax, int ay, int aw,
                                          int ah, int bx, int by, int bw, int bh);
    shape_pair_t s;
    s.op  = op;
    s.a_x = COORD_BITS'(ax);
    s.a_y = COORD_BITS'(ay);
    s.a_w = (COORD_BITS-1)'(aw);
    s.a_h = (COORD_BITS-1)'(ah);
    s.b_x = COORD_BITS'(bx);
    s.b_y = COORD_BITS'(by);
    s.b_w = (COORD_BITS-1)'(bw);
    s.b_h = (COORD_BITS-1)'(bh);
    return s;
  endfunction

  function automatic int offset_within(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t s;
    int          mode;
    int          span;
    int          d;
    int          ax, ay, aw, ah, bx, by, bw, bh;
    if ($urandom_range(0, 15) == 0) s.op = OP_BITS'($urandom_range(5, 7));
    else s.op = OP_BITS'($urandom_range(0, 4));
    s.a_x = COORD_BITS'($urandom);
    s.a_y = COORD_BITS'($urandom);
    s.a_w = (COORD_BITS-1)'($urandom);
    s.a_h = (COORD_BITS-1)'($urandom);
    s.b_x = COORD_BITS'($urandom);
    s.b_y = COORD_BITS'($urandom);
    s.b_w = (COORD_BITS-1)'($urandom);
    s.b_h = (COORD_BITS-1)'($urandom);
    mode  = $urandom_range(0, 3);
    if (mode == 2) begin
      s.a_w = s.a_w >> $urandom_range(0, 14);
      s.a_h = s.a_h >> $urandom_range(0, 14);
      s.b_w = s.b_w >> $urandom_range(0, 14);
      s.b_h = s.b_h >> $urandom_range(0, 14);
    end
    ax = int'($signed(s.a_x));
    ay = int'($signed(s.a_y));
    aw = int'(s.a_w);
    ah = int'(s.a_h);
    bx = int'($signed(s.b_x));
    by = int'($signed(s.b_y));
    bw = int'(s.b_w);
    bh = int'(s.b_h);
    d  = int'($urandom_range(0, 2)) - 1;
    if (mode == 1 || mode == 2) begin
      // place b near a so that overlaps and near misses are common
      span  = aw + ah + bw + bh + 1;
      s.b_x = COORD_BITS'(ax + offset_within(span) - bw / 2);
      s.b_y = COORD_BITS'(ay + offset_within(span) - bh / 2);
    end else if (mode == 3) begin
      // exact touching, one step in, one step out
      case (s.op)
        OP_CIRC_CIRC: begin
          s.b_y = s.a_y;
          s.b_x = COORD_BITS'(ax + aw + bw + d);
        end
        OP_CIRC_RECT: begin
          s.b_y = COORD_BITS'(ay - bh / 2);
          s.b_x = COORD_BITS'(ax + aw + d);
        end
        OP_RECT_RECT: begin
          s.b_x = COORD_BITS'(ax + aw + d);
          s.b_y = COORD_BITS'(ay + offset_within(ah + 1));
        end
        OP_PT_CIRC: begin
          s.a_y = s.b_y;
          s.a_x = COORD_BITS'(bx + bw + d);
        end
        OP_PT_RECT: begin
          s.a_x = COORD_BITS'(bx + bw + d);
          s.a_y = COORD_BITS'(by + int'($urandom_range(0, bh)));
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  task automatic send_pair(input shape_pair_t s, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    drive_pair <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_directed();
    // coincident zero-radius circles, far-apart extreme circles
    send_pair(pair_of(OP_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_CIRC, 32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767),
              $urandom_range(0, 6));
    // touching circles and one step apart
    send_pair(pair_of(OP_CIRC_CIRC, 0, 0, 4096, 0, 8192, 0, 4096, 0), $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_CIRC, 0, 0, 4096, 0, 8193, 0, 4096, 0), $urandom_range(0, 6));
    // diagonal touch on a 3-4-5 triangle
    send_pair(pair_of(OP_CIRC_CIRC, 0, 0, 10240, 0, 12288, 16384, 10240, 0), $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_CIRC, 0, 0, 10240, 0, 12288, 16384, 10239, 0), $urandom_range(0, 6));
    // circle centre inside the rectangle
    send_pair(pair_of(OP_CIRC_RECT, 100, 100, 0, 0, 0, 0, 200, 200), $urandom_range(0, 6));
    // beside an edge: touching and just short
    send_pair(pair_of(OP_CIRC_RECT, -1000, 100, 1000, 0, 0, 0, 200, 200), $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_RECT, -1000, 100, 999, 0, 0, 0, 200, 200), $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_RECT, 100, 1200, 1000, 0, 0, 0, 200, 200), $urandom_range(0, 6));
    // beyond a corner: touching, just short, and extreme coordinates
    send_pair(pair_of(OP_CIRC_RECT, -12288, -16384, 20480, 0, 0, 0, 4096, 4096),
              $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_RECT, -12288, -16384, 20479, 0, 0, 0, 4096, 4096),
              $urandom_range(0, 6));
    send_pair(pair_of(OP_CIRC_RECT, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767),
              $urandom_range(0, 6));
    // adjacent rectangles, a one-step gap, and extreme coordinates
    send_pair(pair_of(OP_RECT_RECT, 0, 0, 100, 100, 100, 0, 50, 50), $urandom_range(0, 6));
    send_pair(pair_of(OP_RECT_RECT, 0, 0, 100, 100, 101, 0, 50, 50), $urandom_range(0, 6));
    send_pair(pair_of(OP_RECT_RECT, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767),
              $urandom_range(0, 6));
    // point on the circle and just outside
    send_pair(pair_of(OP_PT_CIRC, 4096, 0, 0, 0, 0, 0, 4096, 0), $urandom_range(0, 6));
    send_pair(pair_of(OP_PT_CIRC, 4097, 0, 0, 0, 0, 0, 4096, 0), $urandom_range(0, 6));
    // point on a rectangle corner, just outside, and extreme sizes
    send_pair(pair_of(OP_PT_RECT, 300, 400, 0, 0, 100, 200, 200, 200), $urandom_range(0, 6));
    send_pair(pair_of(OP_PT_RECT, 99, 200, 0, 0, 100, 200, 200, 200), $urandom_range(0, 6));
    send_pair(pair_of(OP_PT_RECT, 32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767),
              $urandom_range(0, 6));
    // unused opcodes, with fields all ones, mixed and all zeros
    send_pair(pair_of(OP_BITS'(5), -1, -1, 32767, 32767, -1, -1, 32767, 32767), 0);
    send_pair(pair_of(OP_BITS'(6), 0, 0, 32767, 32767, 0, 0, 32767, 32767), 0);
    send_pair(pair_of(OP_BITS'(7), 0, 0, 0, 0, 0, 0, 0, 0), $urandom_range(0, 6));
  endtask

  initial begin
    bit no_idle;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_pair(random_pair(), no_idle ? 0 : $urandom_range(0, 6));
    end
    start <= 1'b0;
    while (hits.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hits.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
